// ----- rtl/core/bqm_pkg.sv -----
// ----------------------------------------------------------------------------
// bqm_pkg
// Shared types, constants and fraction table for the quad cell mesher.
// ----------------------------------------------------------------------------
package bqm_pkg;

    localparam int MAX_DIV_DEF = 8;
    localparam int ONE_Q16     = 65536;

    // Input item: one quadrilateral and its subdivision counts
    typedef struct packed {
        logic signed [31:0] corner0_y;
        logic signed [31:0] corner0_z;
        logic signed [31:0] corner1_y;
        logic signed [31:0] corner1_z;
        logic signed [31:0] corner2_y;
        logic signed [31:0] corner2_z;
        logic signed [31:0] corner3_y;
        logic signed [31:0] corner3_z;
        logic        [3:0]  div_ij;
        logic        [3:0]  div_jk;
    } quad_t;

    // Result item: one cell
    typedef struct packed {
        logic        [5:0]  cell_index;
        logic signed [31:0] out0_y;
        logic signed [31:0] out0_z;
        logic signed [31:0] out1_y;
        logic signed [31:0] out1_z;
        logic signed [31:0] out2_y;
        logic signed [31:0] out2_z;
        logic signed [31:0] out3_y;
        logic signed [31:0] out3_z;
        logic               last_cell;
    } cell_t;

    // Work descriptor handed from front to back (counts already clamped)
    typedef struct packed {
        logic [3:0][31:0] cy;
        logic [3:0][31:0] cz;
        logic [3:0]       nij;
        logic [3:0]       njk;
    } job_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT
    } back_state_t;

    // Grid fraction t/n in Q1.16, round half up; row n, column t
    localparam logic [16:0] FRAC_TAB [0:8][0:8] = '{
        '{17'd0, 17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,
          17'd0, 17'd0},
        '{17'd0, 17'd65536, 17'd0,     17'd0,     17'd0,     17'd0,     17'd0,
          17'd0, 17'd0},
        '{17'd0, 17'd32768, 17'd65536, 17'd0,     17'd0,     17'd0,     17'd0,
          17'd0, 17'd0},
        '{17'd0, 17'd21845, 17'd43691, 17'd65536, 17'd0,     17'd0,     17'd0,
          17'd0, 17'd0},
        '{17'd0, 17'd16384, 17'd32768, 17'd49152, 17'd65536, 17'd0,     17'd0,
          17'd0, 17'd0},
        '{17'd0, 17'd13107, 17'd26214, 17'd39322, 17'd52429, 17'd65536, 17'd0,
          17'd0, 17'd0},
        '{17'd0, 17'd10923, 17'd21845, 17'd32768, 17'd43691, 17'd54613, 17'd65536,
          17'd0, 17'd0},
        '{17'd0, 17'd9362,  17'd18725, 17'd28087, 17'd37449, 17'd46811, 17'd56174,
          17'd65536, 17'd0},
        '{17'd0, 17'd8192,  17'd16384, 17'd24576, 17'd32768, 17'd40960, 17'd49152,
          17'd57344, 17'd65536}
    };

endpackage

// ----- rtl/core/bqm_front.sv -----
// ----------------------------------------------------------------------------
// bqm_front
// Accepts quads, clamps the counts and drops quads that yield no cells.
// ----------------------------------------------------------------------------
module bqm_front
    import bqm_pkg::*;
#(
    parameter int MAX_DIV = MAX_DIV_DEF
) (
    input  logic  push,
    output logic  full,
    input  quad_t quad,
    input  logic  q_full,
    output logic  q_wr,
    output job_t  q_data
);

    logic       accept;
    logic [3:0] nij;
    logic [3:0] njk;

    // Count clamp
    assign nij = (quad.div_ij > 4'(MAX_DIV)) ? 4'(MAX_DIV) : quad.div_ij;
    assign njk = (quad.div_jk > 4'(MAX_DIV)) ? 4'(MAX_DIV) : quad.div_jk;

    // Transfer in; empty grids are consumed without a job
    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_wr   = accept && (nij != 4'd0) && (njk != 4'd0);

    always_comb
    begin
        q_data.cy  = {quad.corner3_y, quad.corner2_y, quad.corner1_y, quad.corner0_y};
        q_data.cz  = {quad.corner3_z, quad.corner2_z, quad.corner1_z, quad.corner0_z};
        q_data.nij = nij;
        q_data.njk = njk;
    end

endmodule

// ----- rtl/core/bqm_queue.sv -----
// ----------------------------------------------------------------------------
// bqm_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module bqm_queue
    import bqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_data,
    output logic q_full,
    output logic q_empty,
    input  logic rd,
    output job_t rd_data
);

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(wr) - 2'(rd);
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/bqm_back.sv -----
// ----------------------------------------------------------------------------
// bqm_back
// Walks the cell grid of one job and interpolates each cell corner.
// ----------------------------------------------------------------------------
module bqm_back
    import bqm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_empty,
    input  job_t  q_data,
    output logic  q_rd,
    output logic  empty,
    input  logic  pop,
    output cell_t mesh_cell
);

    back_state_t      state_reg;
    back_state_t      state_next;
    job_t             job_reg;
    logic [3:0]       i_reg;
    logic [3:0]       j_reg;
    logic [5:0]       k_reg;
    logic [1:0]       corner_reg;
    logic [3:0]       i_next;
    logic [3:0]       j_next;
    logic [5:0]       k_next;
    logic [1:0]       corner_next;
    logic             load;
    logic             emit;
    logic             last;
    logic [3:0]       ci;
    logic [3:0]       cj;
    logic [16:0]      u;
    logic [16:0]      v;
    logic signed [49:0] r0y_reg, r1y_reg, r0z_reg, r1z_reg;
    logic signed [49:0] r0y_next, r1y_next, r0z_next, r1z_next;
    logic [16:0]      v_reg;
    logic [3:0][31:0] ry_reg;
    logic [3:0][31:0] rz_reg;
    logic [31:0]      res_y;
    logic [31:0]      res_z;
    logic             out_valid_reg;
    cell_t            out_reg;
    logic signed [17:0] wu0, wu1, wv0, wv1;
    logic signed [67:0] sy, sz;

    assign empty     = !out_valid_reg;
    assign mesh_cell = out_reg;
    assign last      = (i_reg == job_reg.nij - 4'd1) && (j_reg == job_reg.njk - 4'd1);

    // Grid point of the current corner: I (i,j), J (i+1,j), K (i+1,j+1), L (i,j+1)
    assign ci = i_reg + 4'((corner_reg == 2'd1) || (corner_reg == 2'd2));
    assign cj = j_reg + 4'((corner_reg == 2'd2) || (corner_reg == 2'd3));
    assign u  = FRAC_TAB[job_reg.nij][ci];
    assign v  = FRAC_TAB[job_reg.njk][cj];

    // Stage one: blend along IJ and LK at fraction u (operands widened first)
    assign wu1 = $signed({1'b0, u});
    assign wu0 = $signed(18'(ONE_Q16) - {1'b0, u});
    assign r0y_next = 50'($signed(job_reg.cy[0])) * wu0 + 50'($signed(job_reg.cy[1])) * wu1;
    assign r1y_next = 50'($signed(job_reg.cy[3])) * wu0 + 50'($signed(job_reg.cy[2])) * wu1;
    assign r0z_next = 50'($signed(job_reg.cz[0])) * wu0 + 50'($signed(job_reg.cz[1])) * wu1;
    assign r1z_next = 50'($signed(job_reg.cz[3])) * wu0 + 50'($signed(job_reg.cz[2])) * wu1;

    // Stage two: blend the two rows at fraction v, round half up
    assign wv1   = $signed({1'b0, v_reg});
    assign wv0   = $signed(18'(ONE_Q16) - {1'b0, v_reg});
    assign sy    = 68'(r0y_reg) * wv0 + 68'(r1y_reg) * wv1 + 68'sh80000000;
    assign sz    = 68'(r0z_reg) * wv0 + 68'(r1z_reg) * wv1 + 68'sh80000000;
    assign res_y = sy[63:32];
    assign res_z = sz[63:32];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        corner_next = corner_reg;
        load        = 1'b0;
        emit        = 1'b0;
        q_rd        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    load        = 1'b1;
                    q_rd        = 1'b1;
                    i_next      = 4'd0;
                    j_next      = 4'd0;
                    k_next      = 6'd0;
                    corner_next = 2'd0;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (corner_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = ST_MUL1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    emit        = 1'b1;
                    corner_next = 2'd0;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = ST_MUL1;
                        if (i_reg == job_reg.nij - 4'd1)
                        begin
                            i_next = 4'd0;
                            j_next = j_reg + 4'd1;
                        end
                        else
                        begin
                            i_next = i_reg + 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= 4'd0;
            j_reg         <= 4'd0;
            k_reg         <= 6'd0;
            corner_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            corner_reg <= corner_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= q_data;
        end
        if (state_reg == ST_MUL1)
        begin
            r0y_reg <= r0y_next;
            r1y_reg <= r1y_next;
            r0z_reg <= r0z_next;
            r1z_reg <= r1z_next;
            v_reg   <= v;
        end
        if (state_reg == ST_MUL2)
        begin
            ry_reg[corner_reg] <= res_y;
            rz_reg[corner_reg] <= res_z;
        end
        if (emit)
        begin
            out_reg.cell_index <= k_reg;
            out_reg.out0_y     <= ry_reg[0];
            out_reg.out0_z     <= rz_reg[0];
            out_reg.out1_y     <= ry_reg[1];
            out_reg.out1_z     <= rz_reg[1];
            out_reg.out2_y     <= ry_reg[2];
            out_reg.out2_z     <= rz_reg[2];
            out_reg.out3_y     <= ry_reg[3];
            out_reg.out3_z     <= rz_reg[3];
            out_reg.last_cell  <= last;
        end
    end

`ifndef SYNTH
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside emit");

    a_grid_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (i_reg < job_reg.nij) && (j_reg < job_reg.njk))
        else $error("grid position out of range");

    a_index_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |->
            (k_reg == 6'(j_reg) * 6'(job_reg.nij) + 6'(i_reg)))
        else $error("cell index out of step with grid position");
`endif

endmodule

// ----- rtl/core/bilinear_quad_cell_mesher_core.sv -----
// Per cell, the sequencer runs the shared two-stage corner multiplier pass (MUL1, MUL2)
// once for each of the four corners, then emits; emit waits while the previous cell is
// unpopped, and the next cell starts only after the emit. A quad gives up to 64 cells.
// Quads with a zero count are consumed without entering the queue and give no cells.
// Reset: asynchronous, active low; clears the queue and the sequencer.
// ----------------------------------------------------------------------------
// bilinear_quad_cell_mesher_core
// Splits a quadrilateral into a grid of bilinear cells, one result per cell.
// ----------------------------------------------------------------------------
module bilinear_quad_cell_mesher_core
    import bqm_pkg::*;
#(
    parameter int MAX_DIV = MAX_DIV_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  quad_t quad,
    output logic  empty,
    input  logic  pop,
    output cell_t mesh_cell
);

    logic q_full;
    logic q_empty;
    logic q_wr;
    logic q_rd;
    job_t q_wdata;
    job_t q_rdata;

    // Front: classify and clamp
    bqm_front #(
        .MAX_DIV (MAX_DIV)
    ) u_front (
        .push   (push),
        .full   (full),
        .quad   (quad),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_wdata)
    );

    // Job queue
    bqm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .q_empty (q_empty),
        .rd      (q_rd),
        .rd_data (q_rdata)
    );

    // Back: cell walk and interpolation
    bqm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .mesh_cell (mesh_cell)
    );

endmodule

// ----- tb/tb_bilinear_quad_cell_mesher_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_quad_cell_mesher_core
// Drives quads into the cell mesher and checks every cell it emits against a
// bilinear predictor in Q16.16, with random idling on both sides, a long
// receiver hold-off to fill the block, and a drain pause.
// ----------------------------------------------------------------------------
module tb_bilinear_quad_cell_mesher_core;
    import bqm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIV_LIMIT      = 8;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  push = 1'b0;
    logic  full;
    quad_t quad = '0;
    logic  empty;
    logic  pop = 1'b0;
    cell_t mesh_cell;

    cell_t cells_expected[$];
    int    errors = 0;
    bit    idle_en = 1'b1;
    int    hold_cycles = 0;
    int    pop_gap = 0;
    int    quiet_cycles = 0;

    bilinear_quad_cell_mesher_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .quad      (quad),
        .empty     (empty),
        .pop       (pop),
        .mesh_cell (mesh_cell)
    );

    always #4 clk = ~clk;

    // Grid fraction t/n in Q1.16, round half up
    function automatic logic [16:0] grid_frac(int unsigned t, int unsigned n);
        return 17'((2 * t * ONE_Q16 + n) / (2 * n));
    endfunction

    // Weighted sum of four corner values, rounded to nearest, ties up
    function automatic logic [31:0] blend_coord(logic [3:0][31:0] c,
                                                logic [16:0] u, logic [16:0] v);
        logic signed [95:0] acc;
        logic signed [95:0] w [4];
        acc  = '0;
        w[0] = 96'((33'(ONE_Q16) - u) * (33'(ONE_Q16) - v));
        w[1] = 96'(33'(u) * (33'(ONE_Q16) - v));
        w[2] = 96'(33'(u) * 33'(v));
        w[3] = 96'((33'(ONE_Q16) - u) * 33'(v));
        for (int s = 0; s < 4; s++)
        begin
            acc += 96'(signed'(c[s])) * w[s];
        end
        acc = (acc + 96'sh8000_0000) >>> 32;
        return acc[31:0];
    endfunction

    // Expected cells of one quad, row along JK outer, column along IJ inner
    task automatic predict_cells(quad_t q);
        logic [3:0][31:0] cy, cz;
        int unsigned      nij, njk, k;
        logic [16:0]      fu [DIV_LIMIT + 1];
        logic [16:0]      fv [DIV_LIMIT + 1];
        logic [16:0]      cu [4];
        logic [16:0]      cv [4];
        cell_t            c;
        nij = (q.div_ij > DIV_LIMIT) ? DIV_LIMIT : q.div_ij;
        njk = (q.div_jk > DIV_LIMIT) ? DIV_LIMIT : q.div_jk;
        k   = 0;
        if (nij == 0 || njk == 0)
        begin
            return;
        end
        cy = {q.corner3_y, q.corner2_y, q.corner1_y, q.corner0_y};
        cz = {q.corner3_z, q.corner2_z, q.corner1_z, q.corner0_z};
        for (int t = 0; t <= nij; t++)
        begin
            fu[t] = grid_frac(t, nij);
        end
        for (int t = 0; t <= njk; t++)
        begin
            fv[t] = grid_frac(t, njk);
        end
        for (int j = 0; j < njk; j++)
        begin
            for (int i = 0; i < nij; i++)
            begin
                cu = '{fu[i], fu[i + 1], fu[i + 1], fu[i]};
                cv = '{fv[j], fv[j], fv[j + 1], fv[j + 1]};
                c.cell_index = 6'(k);
                c.out0_y     = blend_coord(cy, cu[0], cv[0]);
                c.out0_z     = blend_coord(cz, cu[0], cv[0]);
                c.out1_y     = blend_coord(cy, cu[1], cv[1]);
                c.out1_z     = blend_coord(cz, cu[1], cv[1]);
                c.out2_y     = blend_coord(cy, cu[2], cv[2]);
                c.out2_z     = blend_coord(cz, cu[2], cv[2]);
                c.out3_y     = blend_coord(cy, cu[3], cv[3]);
                c.out3_z     = blend_coord(cz, cu[3], cv[3]);
                c.last_cell  = (k + 1 == nij * njk);
                cells_expected.push_back(c);
                k++;
            end
        end
    endtask

    // One input transfer; push stays high afterwards
    task automatic send_quad(quad_t q);
        push <= 1'b1;
        quad <= q;
        forever
        begin
            @(negedge clk);
            if (!full)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        predict_cells(q);
    endtask

    // Random sender gap with push low, taken on one call in four while idling is enabled
    task automatic sender_idle();
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        while (cells_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic quad_t rand_quad(bit big);
        quad_t q;
        q.corner0_y = rand_coord();
        q.corner0_z = rand_coord();
        q.corner1_y = rand_coord();
        q.corner1_z = rand_coord();
        q.corner2_y = rand_coord();
        q.corner2_z = rand_coord();
        q.corner3_y = rand_coord();
        q.corner3_z = rand_coord();
        if (big || $urandom_range(0, 9) == 0)
        begin
            q.div_ij = 4'($urandom_range(0, 15));
            q.div_jk = 4'($urandom_range(0, 15));
        end
        else
        begin
            q.div_ij = 4'($urandom_range(1, 3));
            q.div_jk = 4'($urandom_range(1, 3));
        end
        return q;
    endfunction

    function automatic quad_t fill_quad(logic [31:0] v, logic [3:0] a, logic [3:0] b);
        quad_t q;
        q = {v, v, v, v, v, v, v, v, a, b};
        return q;
    endfunction

    // Corner extremes, several count cases, zero counts and clamped counts
    task automatic test_directed();
        quad_t q;
        send_quad(fill_quad(32'h7FFF_FFFF, 4'd1, 4'd1));
        send_quad(fill_quad(32'h8000_0000, 4'd2, 4'd2));
        send_quad(fill_quad(32'h0000_0000, 4'd8, 4'd8));
        send_quad(fill_quad(32'hFFFF_FFFF, 4'd0, 4'd5));
        send_quad(fill_quad(32'h0001_0000, 4'd5, 4'd0));
        send_quad(fill_quad(32'h1234_5678, 4'd0, 4'd0));
        // unit square and a skewed quad with mixed extremes
        q = {32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h10000,
             4'd3, 4'd7};
        send_quad(q);
        q = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 4'd6, 4'd5};
        send_quad(q);
        q.div_ij = 4'd15;
        q.div_jk = 4'd9;
        send_quad(q);
        q.div_ij = 4'd1;
        q.div_jk = 4'd8;
        send_quad(q);
        q.div_ij = 4'd8;
        q.div_jk = 4'd1;
        send_quad(q);
        q.div_ij = 4'd10;
        q.div_jk = 4'd15;
        send_quad(q);
        for (int n = 1; n <= 7; n++)
        begin
            send_quad(rand_quad(1'b0));
            sender_idle();
        end
        push <= 1'b0;
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            send_quad(rand_quad(1'b0));
            sender_idle();
        end
        push <= 1'b0;
    endtask

    // Receiver holds off while large quads keep coming, then the bench waits for the drain
    task automatic test_backpressure();
        quad_t q;
        @(negedge clk);
        hold_cycles = 400;
        @(posedge clk);
        for (int n = 0; n < 6; n++)
        begin
            q = rand_quad(1'b0);
            q.div_ij = 4'd8;
            q.div_jk = 4'($urandom_range(4, 8));
            send_quad(q);
        end
        push <= 1'b0;
        wait_drain();
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        test_random(15);
    endtask

    // Receiver: random pop bursts plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else if (pop_gap > 0)
        begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            pop_gap <= $urandom_range(0, 10);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result check: sampled mid-cycle, transfer completes at the next edge
    always @(negedge clk)
    begin
        cell_t exp_c;
        if (rst_n && pop && !empty)
        begin
            if (cells_expected.size() == 0)
            begin
                $display("%0t: unexpected cell, expected none, actual %h", $time, mesh_cell);
                errors++;
            end
            else
            begin
                exp_c = cells_expected.pop_front();
                check_field("cell_index", 32'(exp_c.cell_index), 32'(mesh_cell.cell_index));
                check_field("out0_y", exp_c.out0_y, mesh_cell.out0_y);
                check_field("out0_z", exp_c.out0_z, mesh_cell.out0_z);
                check_field("out1_y", exp_c.out1_y, mesh_cell.out1_y);
                check_field("out1_z", exp_c.out1_z, mesh_cell.out1_z);
                check_field("out2_y", exp_c.out2_y, mesh_cell.out2_y);
                check_field("out2_z", exp_c.out2_z, mesh_cell.out2_z);
                check_field("out3_y", exp_c.out3_y, mesh_cell.out3_y);
                check_field("out3_z", exp_c.out3_z, mesh_cell.out3_z);
                check_field("last_cell", 32'(exp_c.last_cell), 32'(mesh_cell.last_cell));
            end
        end
        // watchdog on cycles without any transfer
        if (rst_n && ((push && !full) || (pop && !empty)))
        begin
            quiet_cycles = 0;
        end
        else if (rst_n)
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100);
        test_backpressure();
        test_random(20);
        test_no_idle();
        wait_drain();
        repeat (700) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bqm_pkg.sv
rtl/core/bqm_front.sv
rtl/core/bqm_queue.sv
rtl/core/bqm_back.sv
rtl/core/bilinear_quad_cell_mesher_core.sv
tb/tb_bilinear_quad_cell_mesher_core.sv
